// ===== hw/rtl/dhf_pkg.sv =====
// Shared types, constants and control structures of the depth hole filler.
package dhf_pkg;

	localparam int DEPTH_BITS     = 18;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_WINDOW     = 9;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int THR_W      = 18;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 7;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic                  op;
		logic [DEPTH_BITS-1:0] depth;
	} in_item_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth_out;
		logic                  last_of_frame;
	} out_item_t;

	typedef struct packed {
		logic store;
		logic read_self;
		logic scan_init;
		logic take_self;
		logic scan;
		logic div_clear;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_ready;
		logic out_full;
		logic self_hole;
		logic scan_last;
		logic div_last;
	} sts_t;

endpackage

// ===== hw/rtl/depth_hole_fill_window_mean.sv =====
// Top level of the depth hole filler with neighbor mean over a clipped window.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_stall  | in_data (op, depth)
//  out     | output    | out_valid, out_stall| out_data (depth_out, last_of_frame)
//  cfg     | input     | cfg_we              | cfg_idx, cfg_data
//
// A pixel supply transfer is a single store. A drain of a pixel that is not a hole
// reads it and writes it back; a hole also scans the clipped window of N cells (up
// to 81) with one memory read per cell and runs a one-bit-per-cycle divider.
// Reset needs no clearing pass over the row memory. A waiting result does not block
// pixel supply; a drain waits until the output register is free.
module depth_hole_fill_window_mean #(
	parameter int MAX_WIDTH  = dhf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dhf_pkg::DEF_MAX_HEIGHT,
	parameter int WINDOW     = dhf_pkg::DEF_WINDOW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  dhf_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output dhf_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [dhf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [dhf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dhf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dhf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.WINDOW     (WINDOW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/dhf_ctrl.sv =====
// Controller state machine that sequences pixel stores, window scans and the divider.
module dhf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_stall,
	input  dhf_pkg::sts_t   sts,
	output dhf_pkg::cmd_t   cmd
);
	import dhf_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_WAIT_SELF = 6'b000010,
		ST_SCAN      = 6'b000100,
		ST_SCAN_TAIL = 6'b001000,
		ST_DIV       = 6'b010000,
		ST_FINISH    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   xfer;

	assign in_stall = (state_q != ST_IDLE) || (in_op == OP_DRAIN && sts.out_full);
	assign xfer     = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (xfer) begin
					if (in_op == OP_PIXEL) begin
						cmd.store = 1'b1;
					end else if (sts.out_ready) begin
						cmd.read_self = 1'b1;
						state_d       = ST_WAIT_SELF;
					end
				end
			end
			ST_WAIT_SELF: begin
				if (sts.self_hole) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					cmd.take_self = 1'b1;
					state_d       = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SCAN_TAIL;
				end
			end
			ST_SCAN_TAIL: begin
				cmd.div_clear = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/dhf_datapath.sv =====
// Datapath: row ring memory, stream positions, window accumulator and serial divider.
module dhf_datapath #(
	parameter int MAX_WIDTH  = dhf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dhf_pkg::DEF_MAX_HEIGHT,
	parameter int WINDOW     = dhf_pkg::DEF_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dhf_pkg::in_item_t                   in_data,
	input  logic                                cfg_we,
	input  logic [dhf_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [dhf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  dhf_pkg::cmd_t                       cmd,
	output dhf_pkg::sts_t                       sts,
	output logic                                out_valid,
	input  logic                                out_stall,
	output dhf_pkg::out_item_t                  out_data
);
	import dhf_pkg::*;

	localparam int WIN_LO   = WINDOW / 2;
	localparam int WIN_HI   = WINDOW - 1 - WIN_LO;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int RING_W   = $clog2(WINDOW);
	localparam int ADDR_W   = $clog2(WINDOW * MAX_WIDTH);
	localparam int CNT_W    = $clog2(WINDOW * WINDOW + 1);
	localparam int SUM_W    = DEPTH_BITS + CNT_W;
	localparam int DCNT_W   = $clog2(SUM_W);

	logic [THR_W-1:0]    thr_q;
	logic [IMG_W_W-1:0]  img_w_q;
	logic [IMG_H_W-1:0]  img_h_q;

	logic [ROW_W-1:0]    in_row_q, out_row_q, sr_q;
	logic [COL_W-1:0]    in_col_q, out_col_q, sc_q;
	logic [RING_W-1:0]   in_ring_q, out_ring_q, sring_q;
	logic                frame_rcvd_q;

	logic [DEPTH_BITS-1:0] mem [WINDOW*MAX_WIDTH];
	logic [DEPTH_BITS-1:0] rd_q, self_q;
	logic                  acc_v_s1, use_self_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      count_q, rem_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [31:0]         w_eff, h_eff;
	logic [COL_W-1:0]    w_m1;
	logic [ROW_W-1:0]    h_m1;
	logic [ROW_W:0]      nr_x, r_hi_x;
	logic [COL_W:0]      nc_x, c_hi_x;
	logic [ROW_W-1:0]    r0, r1;
	logic [COL_W-1:0]    c0, c1;
	logic [RING_W:0]     back, ring0_x;
	logic                drop, restart;
	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   addr, self_addr, in_addr, scan_addr;
	logic [DEPTH_BITS-1:0] wdata, result;
	logic [CNT_W:0]      rem_sh;
	logic                qbit;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [RING_W-1:0] ring,
		logic [COL_W-1:0] col);
		return ADDR_W'(ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
	endfunction

	function automatic logic [RING_W-1:0] ring_inc(logic [RING_W-1:0] ring);
		return (ring == RING_W'(WINDOW - 1)) ? '0 : ring + 1'b1;
	endfunction

	always_comb begin
		w_eff = {21'd0, img_w_q};
		if (w_eff < 32'd1) w_eff = 32'd1;
		if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
		h_eff = {25'd0, img_h_q};
		if (h_eff < 32'd1) h_eff = 32'd1;
		if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
	end
	assign w_m1 = COL_W'(w_eff - 32'd1);
	assign h_m1 = ROW_W'(h_eff - 32'd1);

	assign r_hi_x = {1'b0, out_row_q} + (ROW_W+1)'(WIN_HI);
	assign c_hi_x = {1'b0, out_col_q} + (COL_W+1)'(WIN_HI);
	assign nr_x   = (r_hi_x < {1'b0, h_m1}) ? r_hi_x : {1'b0, h_m1};
	assign nc_x   = (c_hi_x < {1'b0, w_m1}) ? c_hi_x : {1'b0, w_m1};
	assign r1     = nr_x[ROW_W-1:0];
	assign c1     = nc_x[COL_W-1:0];
	assign r0     = (out_row_q >= ROW_W'(WIN_LO)) ? out_row_q - ROW_W'(WIN_LO) : '0;
	assign c0     = (out_col_q >= COL_W'(WIN_LO)) ? out_col_q - COL_W'(WIN_LO) : '0;
	assign back   = (RING_W+1)'(out_row_q - r0);
	assign ring0_x = ({1'b0, out_ring_q} >= back) ? {1'b0, out_ring_q} - back
		: {1'b0, out_ring_q} + (RING_W+1)'(WINDOW) - back;

	assign drop    = frame_rcvd_q || ({1'b0, in_row_q} > r_hi_x);
	assign restart = cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

	assign sts.out_ready = frame_rcvd_q || ({1'b0, in_row_q} > nr_x)
		|| ({1'b0, in_row_q} == nr_x && {1'b0, in_col_q} > nc_x);
	assign sts.out_full  = out_valid_q;
	assign sts.self_hole = rd_q < thr_q;
	assign sts.scan_last = (sr_q == r1) && (sc_q == c1);
	assign sts.div_last  = dcnt_q == DCNT_W'(SUM_W - 1);

	assign self_addr = cell_addr(out_ring_q, out_col_q);
	assign in_addr   = cell_addr(in_ring_q, in_col_q);
	assign scan_addr = cell_addr(sring_q, sc_q);

	assign result = (use_self_q || count_q == '0) ? self_q : sum_q[DEPTH_BITS-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		addr   = self_addr;
		wdata  = result;
		if (cmd.store) begin
			mem_we = !drop;
			addr   = in_addr;
			wdata  = in_data.depth;
		end else if (cmd.read_self) begin
			mem_re = 1'b1;
		end else if (cmd.scan) begin
			mem_re = 1'b1;
			addr   = scan_addr;
		end else if (cmd.finish) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= wdata;
		if (mem_re) rd_q <= mem[addr];
	end

	assign rem_sh = {rem_q, sum_q[SUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.scan_init || cmd.take_self) self_q <= rd_q;
		if (cmd.scan_init) begin
			sr_q    <= r0;
			sc_q    <= c0;
			sring_q <= ring0_x[RING_W-1:0];
			sum_q   <= '0;
			count_q <= '0;
		end else if (cmd.scan) begin
			if (sc_q == c1) begin
				sc_q    <= c0;
				sr_q    <= sr_q + 1'b1;
				sring_q <= ring_inc(sring_q);
			end else begin
				sc_q <= sc_q + 1'b1;
			end
		end
		if (acc_v_s1 && rd_q > thr_q) begin
			sum_q   <= sum_q + SUM_W'(rd_q);
			count_q <= count_q + 1'b1;
		end
		if (cmd.div_clear) begin
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? CNT_W'(rem_sh - {1'b0, count_q}) : rem_sh[CNT_W-1:0];
			sum_q  <= {sum_q[SUM_W-2:0], qbit};
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.finish) begin
			out_q.depth_out     <= result;
			out_q.last_of_frame <= (out_row_q == h_m1) && (out_col_q == w_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THR_W'(10);
			img_w_q      <= IMG_W_W'(870);
			img_h_q      <= IMG_H_W'(64);
			in_row_q     <= '0;
			in_col_q     <= '0;
			in_ring_q    <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_ring_q   <= '0;
			frame_rcvd_q <= 1'b0;
			acc_v_s1     <= 1'b0;
			use_self_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			acc_v_s1 <= cmd.scan;
			if (cmd.take_self) use_self_q <= 1'b1;
			else if (cmd.scan_init) use_self_q <= 1'b0;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
					REG_WIDTH:     img_w_q <= cfg_data[IMG_W_W-1:0];
					REG_HEIGHT:    img_h_q <= cfg_data[IMG_H_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				in_row_q     <= '0;
				in_col_q     <= '0;
				in_ring_q    <= '0;
				out_row_q    <= '0;
				out_col_q    <= '0;
				out_ring_q   <= '0;
				frame_rcvd_q <= 1'b0;
			end else begin
				if (cmd.store && !drop) begin
					if (in_col_q != w_m1) begin
						in_col_q <= in_col_q + 1'b1;
					end else begin
						in_col_q <= '0;
						if (in_row_q != h_m1) begin
							in_row_q  <= in_row_q + 1'b1;
							in_ring_q <= ring_inc(in_ring_q);
						end else begin
							in_row_q     <= '0;
							in_ring_q    <= '0;
							frame_rcvd_q <= 1'b1;
						end
					end
				end
				if (cmd.finish) begin
					out_valid_q <= 1'b1;
					if (out_col_q != w_m1) begin
						out_col_q <= out_col_q + 1'b1;
					end else begin
						out_col_q <= '0;
						if (out_row_q != h_m1) begin
							out_row_q  <= out_row_q + 1'b1;
							out_ring_q <= ring_inc(out_ring_q);
						end else begin
							out_row_q    <= '0;
							out_ring_q   <= '0;
							frame_rcvd_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== dv/depth_hole_fill_window_mean_tb.sv =====
// Self-checking testbench of the depth hole filler with its own predictor and scoreboard.
module depth_hole_fill_window_mean_tb;
	import dhf_pkg::*;

	localparam int RING       = DEF_WINDOW * DEF_MAX_WIDTH;
	localparam int WIN_LO     = DEF_WINDOW / 2;
	localparam int WIN_HI     = DEF_WINDOW - 1 - WIN_LO;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	depth_hole_fill_window_mean DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// Predictor state: ring of pixel rows, registers and stream positions.
	logic [DEPTH_BITS-1:0] px_ring [RING];
	logic [THR_W-1:0]      thr_reg;
	logic [IMG_W_W-1:0]    width_reg;
	logic [IMG_H_W-1:0]    height_reg;
	int unsigned           rx_row, rx_col, tx_row, tx_col;
	bit                    frame_in;

	out_item_t filled_px_q[$];
	int        fails, n_sent, n_checked, n_cfg;
	int        hold_req, hold_done, hold_left, idle_cycles;
	bit        quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
		return height_reg;
	endfunction

	function automatic int unsigned ring_at(int unsigned r, int unsigned c);
		return (r % DEF_WINDOW) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
	endfunction

	function automatic void restart_stream();
		rx_row = 0; rx_col = 0; tx_row = 0; tx_col = 0;
		frame_in = 1'b0;
	endfunction

	function automatic logic [DEPTH_BITS-1:0] neighbor_mean(int unsigned w, int unsigned h);
		logic [DEPTH_BITS-1:0] self_px, v;
		int unsigned r0, r1, c0, c1, cnt;
		longint unsigned acc;
		self_px = px_ring[ring_at(tx_row, tx_col)];
		if (self_px >= thr_reg) return self_px;
		r0 = (tx_row >= WIN_LO) ? tx_row - WIN_LO : 0;
		r1 = (tx_row + WIN_HI < h - 1) ? tx_row + WIN_HI : h - 1;
		c0 = (tx_col >= WIN_LO) ? tx_col - WIN_LO : 0;
		c1 = (tx_col + WIN_HI < w - 1) ? tx_col + WIN_HI : w - 1;
		acc = 0;
		cnt = 0;
		for (int unsigned r = r0; r <= r1; r++)
			for (int unsigned c = c0; c <= c1; c++) begin
				v = px_ring[ring_at(r, c)];
				if (v > thr_reg) begin
					acc += v;
					cnt++;
				end
			end
		if (cnt == 0) return self_px;
		return DEPTH_BITS'(acc / cnt);
	endfunction

	// Advances the predictor by one accepted transfer and queues any filled pixel.
	function automatic void predict_fill(in_item_t it);
		int unsigned w, h, nr, nc;
		out_item_t res;
		w = eff_width();
		h = eff_height();
		if (it.op == OP_PIXEL) begin
			if (frame_in || rx_row > tx_row + WIN_HI) return;
			px_ring[ring_at(rx_row, rx_col)] = it.depth;
			if (rx_col + 1 < w) begin
				rx_col++;
			end else begin
				rx_col = 0;
				if (rx_row + 1 < h) begin
					rx_row++;
				end else begin
					rx_row = 0;
					frame_in = 1'b1;
				end
			end
			return;
		end
		nr = (tx_row + WIN_HI < h - 1) ? tx_row + WIN_HI : h - 1;
		nc = (tx_col + WIN_HI < w - 1) ? tx_col + WIN_HI : w - 1;
		if (!frame_in && !(rx_row > nr || (rx_row == nr && rx_col > nc))) return;
		res.depth_out = neighbor_mean(w, h);
		res.last_of_frame = (tx_row == h - 1) && (tx_col == w - 1);
		px_ring[ring_at(tx_row, tx_col)] = res.depth_out;
		filled_px_q.insert(filled_px_q.size(), res);
		if (tx_col + 1 < w) begin
			tx_col++;
		end else begin
			tx_col = 0;
			if (tx_row + 1 < h) begin
				tx_row++;
			end else begin
				tx_row = 0;
				frame_in = 1'b0;
			end
		end
	endfunction

	// Output side: random stall, long holds on request, scoreboard and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (filled_px_q.size() == 0) begin
					$error("unexpected transfer: depth_out %0d last_of_frame %0d",
						out_data.depth_out, out_data.last_of_frame);
					fails++;
				end else begin
					if (out_data.depth_out !== filled_px_q[0].depth_out) begin
						$error("depth_out expected %0d actual %0d",
							filled_px_q[0].depth_out, out_data.depth_out);
						fails++;
					end
					if (out_data.last_of_frame !== filled_px_q[0].last_of_frame) begin
						$error("last_of_frame expected %0d actual %0d",
							filled_px_q[0].last_of_frame, out_data.last_of_frame);
						fails++;
					end
					void'(filled_px_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_done < hold_req) begin
				hold_done++;
				hold_left = 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 26);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(logic op, logic [DEPTH_BITS-1:0] depth);
		in_item_t it;
		it.op = op;
		it.depth = depth;
		if (!quiet) begin
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		n_sent++;
		predict_fill(it);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (filled_px_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		drain_all();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
		if (idx == REG_THRESHOLD) begin
			thr_reg = THR_W'(val);
		end else if (idx == REG_WIDTH) begin
			width_reg = IMG_W_W'(val);
			restart_stream();
		end else if (idx == REG_HEIGHT) begin
			height_reg = IMG_H_W'(val);
			restart_stream();
		end
	endtask

	task automatic set_image(int unsigned thr, int unsigned w, int unsigned h);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	function automatic logic [DEPTH_BITS-1:0] pick_depth();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			2: return thr_reg;
			3: return (thr_reg > 0) ? thr_reg - DEPTH_BITS'($urandom_range(1, 3)) : '0;
			4: return thr_reg + DEPTH_BITS'($urandom_range(1, 500));
			default: return DEPTH_BITS'($urandom);
		endcase
	endfunction

	// Sends a random mix of pixels and drains, about drain_pct percent of them drains.
	task automatic run_mix(int n, int drain_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < drain_pct)
				send_item(OP_DRAIN, DEPTH_BITS'($urandom));
			else
				send_item(OP_PIXEL, pick_depth());
		end
	endtask

	task automatic test_directed();
		set_image(10, 3, 2);
		send_item(OP_DRAIN, 0);
		send_item(OP_PIXEL, 0);
		send_item(OP_PIXEL, 10);
		send_item(OP_PIXEL, 18'h3FFFF);
		send_item(OP_PIXEL, 11);
		send_item(OP_PIXEL, 5);
		send_item(OP_PIXEL, 18'h2AAAA);
		send_item(OP_PIXEL, 18'h15555);
		repeat (6) send_item(OP_DRAIN, 18'h3FFFF);
		send_item(OP_DRAIN, 0);
		set_image(18'h3FFFF, 2, 1);
		send_item(OP_PIXEL, 3);
		send_item(OP_PIXEL, 18'h3FFFF);
		repeat (2) send_item(OP_DRAIN, 0);
		write_reg(REG_THRESHOLD, 0);
		send_item(OP_PIXEL, 0);
		send_item(OP_PIXEL, 7);
		repeat (2) send_item(OP_DRAIN, 0);
		drain_all();
	endtask

	task automatic test_size_extremes();
		set_image(10, 1024, 1);
		for (int i = 0; i < 40; i++) send_item(OP_PIXEL, pick_depth());
		repeat (36) send_item(OP_DRAIN, 0);
		set_image(100, 2047, 0);
		run_mix(60, 40);
		set_image(100, 0, 127);
		run_mix(150, 45);
		set_image(1000, 1, 64);
		run_mix(150, 45);
		drain_all();
	endtask

	task automatic test_random_frames();
		int unsigned w, h, n;
		while (n_sent < 1300) begin
			case ($urandom_range(3))
				0: write_reg(REG_THRESHOLD, $urandom_range(0, 40));
				1: write_reg(REG_THRESHOLD, $urandom_range(0, 18'h3FFFF));
				2: write_reg(REG_THRESHOLD, 18'h3FFFF);
				default: write_reg(REG_THRESHOLD, 1000);
			endcase
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 14);
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			n = 2 * w * h + $urandom_range(0, 10);
			if ($urandom_range(3) == 0)
				run_mix(n, $urandom_range(10, 90));
			else
				run_mix(n, 48);
			drain_all();
		end
	endtask

	task automatic test_backpressure();
		set_image(50, 10, 12);
		hold_req++;
		run_mix(120, 50);
		drain_all();
	endtask

	task automatic test_sender_pause();
		set_image(50, 8, 10);
		run_mix(60, 45);
		drain_all();
		run_mix(80, 55);
		drain_all();
	endtask

	task automatic test_no_idle();
		set_image(200, 6, 11);
		quiet = 1'b1;
		run_mix(200, 50);
		drain_all();
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		fails = 0;
		n_sent = 0;
		n_checked = 0;
		n_cfg = 0;
		hold_req = 0;
		hold_done = 0;
		hold_left = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		thr_reg = 10;
		width_reg = 870;
		height_reg = 64;
		restart_stream();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_backpressure();
		test_sender_pause();
		test_no_idle();
		test_random_frames();
		drain_all();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d input transfers and checked %0d filled pixels over %0d register writes,",
			n_sent, n_checked, n_cfg);
		$display("covering size extremes, threshold corners, backpressure and full frames.");
		if (fails == 0 && filled_px_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dhf_pkg.sv
hw/rtl/dhf_ctrl.sv
hw/rtl/dhf_datapath.sv
hw/rtl/depth_hole_fill_window_mean.sv
dv/depth_hole_fill_window_mean_tb.sv
